// ----- src/tcae_pkg.sv -----
// Shared types, character codes and colour helpers for the text console engine.
package tcae_pkg;

  // Command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes (decoded from paddr[2])
  localparam logic REG_DEF_FG = 1'b0;
  localparam logic REG_DEF_BG = 1'b1;

  // Reset values of the default colours
  localparam logic [3:0] FG_RST = 4'd7;
  localparam logic [2:0] BG_RST = 3'd0;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SGR_M = 8'h6D;

  // SGR codes
  localparam logic [7:0] SGR_RESET  = 8'd0;
  localparam logic [7:0] SGR_BOLD   = 8'd1;
  localparam logic [7:0] SGR_FG_LO  = 8'd30;
  localparam logic [7:0] SGR_FG_HI  = 8'd37;
  localparam logic [7:0] SGR_FG_DEF = 8'd39;
  localparam logic [7:0] SGR_BG_LO  = 8'd40;
  localparam logic [7:0] SGR_BG_HI  = 8'd47;
  localparam logic [7:0] SGR_BG_DEF = 8'd49;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  char_byte;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [10:0] cursor_location;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        escape_active;
  } out_item_t;

  // Parser status seen by the controller
  typedef struct packed {
    logic       in_seq;
    logic [3:0] fg;
    logic [2:0] bg;
  } sgr_stat_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [2:0] bg;
    logic       bold;
  } attr_t;

  // ANSI colour order to VGA colour order
  function automatic logic [2:0] sgr_colour(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0: c = 3'd0;
      3'd1: c = 3'd4;
      3'd2: c = 3'd2;
      3'd3: c = 3'd6;
      3'd4: c = 3'd1;
      3'd5: c = 3'd5;
      3'd6: c = 3'd3;
      3'd7: c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Apply one SGR code to the attribute
  function automatic attr_t apply_code(input logic [7:0] code, input attr_t a,
                                       input logic [3:0] dfg, input logic [2:0] dbg);
    attr_t r;
    logic [7:0] off;
    r = a;
    off = 8'd0;
    if (code == SGR_RESET) begin
      r.fg = dfg;
      r.bg = dbg;
      r.bold = 1'b0;
    end else if (code == SGR_BOLD) begin
      if (!a.bold) r.fg = a.fg + 4'd8;
      r.bold = 1'b1;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      off = code - SGR_FG_LO;
      r.fg = {a.bold, sgr_colour(off[2:0])};
    end else if (code == SGR_FG_DEF) begin
      r.fg = dfg;
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      off = code - SGR_BG_LO;
      r.bg = sgr_colour(off[2:0]);
    end else if (code == SGR_BG_DEF) begin
      r.bg = dbg;
    end
    return r;
  endfunction

endpackage

// ----- src/tcae_cell_ram.sv -----
// Cell store: one write port, one read port, registered read data.
module tcae_cell_ram import tcae_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tcae_sgr.sv -----
// Escape sequence parser and colour attribute state.
module tcae_sgr import tcae_pkg::*; #(
  parameter int MAX_SGR_PARAMS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       strobe_i,
  input  logic [7:0] byte_i,
  input  logic [3:0] def_fg_i,
  input  logic [2:0] def_bg_i,
  output logic       consumed_o,
  output sgr_stat_t  stat_o
);

  localparam int NW = $clog2(MAX_SGR_PARAMS + 1);

  logic          in_seq_q, in_seq_d;
  logic [7:0]    acc_q, acc_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [7:0]    nums_q [MAX_SGR_PARAMS];
  logic [7:0]    nums_d [MAX_SGR_PARAMS];
  attr_t         attr_q, attr_d;
  logic [11:0]   dec_sum;
  logic [7:0]    digit;

  assign consumed_o = in_seq_q || (byte_i == CH_ESC);
  assign stat_o = '{in_seq: in_seq_q, fg: attr_q.fg, bg: attr_q.bg};

  // Byte interpretation
  always_comb begin
    in_seq_d = in_seq_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    nums_d   = nums_q;
    attr_d   = attr_q;
    digit    = byte_i - CH_ZERO;
    dec_sum  = 12'(acc_q) * 12'd10 + 12'(digit);
    if (strobe_i) begin
      if (!in_seq_q) begin
        if (byte_i == CH_ESC) in_seq_d = 1'b1;
      end else if (byte_i == CH_LBRK) begin
        in_seq_d = 1'b1;
      end else if (byte_i >= CH_ZERO && byte_i <= CH_NINE) begin
        acc_d = (dec_sum > 12'd255) ? 8'd255 : dec_sum[7:0];
      end else if (byte_i == CH_SEMI || byte_i == CH_SGR_M) begin
        // store the pending number
        if (32'(cnt_q) < MAX_SGR_PARAMS) begin
          for (int i = 0; i < MAX_SGR_PARAMS; i++) begin
            if (32'(cnt_q) == i) nums_d[i] = acc_q;
          end
          cnt_d = cnt_q + NW'(1);
        end
        acc_d = 8'd0;
        if (byte_i == CH_SGR_M) begin
          for (int i = 0; i < MAX_SGR_PARAMS; i++) begin
            if (i < 32'(cnt_d)) attr_d = apply_code(nums_d[i], attr_d, def_fg_i, def_bg_i);
          end
          in_seq_d = 1'b0;
          cnt_d    = '0;
        end
      end else begin
        in_seq_d = 1'b0;
        acc_d    = 8'd0;
        cnt_d    = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q <= 1'b0;
      acc_q    <= 8'd0;
      cnt_q    <= '0;
      attr_q   <= '{fg: FG_RST, bg: BG_RST, bold: 1'b0};
      for (int i = 0; i < MAX_SGR_PARAMS; i++) nums_q[i] <= 8'd0;
    end else begin
      in_seq_q <= in_seq_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      attr_q   <= attr_d;
      nums_q   <= nums_d;
    end
  end

endmodule

// ----- src/text_console_ansi_engine.sv -----
// Top level of the text console engine: controller, cell store and config port.
//
// Text console engine with a ROWS x COLUMNS store of 16-bit cell words held
// in one single-port-write memory. After reset the block runs a clearing pass
// over all ROWS*COLUMNS cells (2000 at the defaults) before it takes its first
// item. A put byte, escape sequence bytes included, loads its result from
// S_DONE; a read command goes through S_READ first, since the memory read data
// is registered. The controller is back in idle at the edge that loads the
// result, so it takes no new item before it is through with the last one. A
// form feed sweeps the store in S_FILL; a scroll moves (ROWS-1)*COLUMNS cells
// at one cell per cycle through the memory's read and write ports, then blanks
// the last row. The result waits in an output register, and a stalled output
// holds the next item back.
module text_console_ansi_engine import tcae_pkg::*; #(
  parameter int COLUMNS        = 80,
  parameter int ROWS           = 25,
  parameter int MAX_SGR_PARAMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_MOVE = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW0 = AW'((ROWS - 1) * COLUMNS);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          pend_q, pend_d;
  logic [15:0]   fill_word_q, fill_word_d;
  logic          rd_ok_q, rd_ok_d;
  logic [15:0]   cell_q, cell_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;
  logic [3:0]    dfg_q;
  logic [2:0]    dbg_q;

  logic          accept;
  logic          sgr_strobe, consumed;
  sgr_stat_t     sgr_stat;
  logic [15:0]   blank;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [CW:0]   col_n, col_tab;
  logic [RW:0]   row_n;
  logic [AW-1:0] cur_idx;
  logic [11:0]   cur_loc;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DEF_BG) ? {29'd0, dbg_q} : {28'd0, dfg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfg_q <= FG_RST;
      dbg_q <= BG_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DEF_FG) dfg_q <= pwdata[3:0];
      else dbg_q <= pwdata[2:0];
    end
  end

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign sgr_strobe = accept && (in_data_i.cmd == CMD_PUT);

  tcae_sgr #(.MAX_SGR_PARAMS(MAX_SGR_PARAMS)) u_sgr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .strobe_i   (sgr_strobe),
    .byte_i     (in_data_i.char_byte),
    .def_fg_i   (dfg_q),
    .def_bg_i   (dbg_q),
    .consumed_o (consumed),
    .stat_o     (sgr_stat)
  );

  tcae_cell_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign blank   = {1'b0, sgr_stat.bg, sgr_stat.fg, CH_SPACE};
  assign cur_idx = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign cur_loc = 12'(row_q) * 12'(COLUMNS) + 12'(col_q);
  assign col_tab = ((CW+1)'(col_q) + (CW+1)'(8)) & ~(CW+1)'(7);

  // Controller
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    fill_word_d = fill_word_q;
    rd_ok_d     = rd_ok_q;
    cell_d      = cell_q;
    row_d       = row_q;
    col_d       = col_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = ptr_q;
    wdata       = fill_word_q;
    re          = 1'b0;
    raddr       = ptr_q;
    col_n       = (CW+1)'(col_q);
    row_n       = (RW+1)'(row_q);
    case (state_q)
      S_INIT: begin
        we    = 1'b1;
        wdata = {1'b0, BG_RST, FG_RST, CH_SPACE};
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cell_d  = 16'd0;
          state_d = S_DONE;
          if (in_data_i.cmd == CMD_READ) begin
            re      = 1'b1;
            raddr   = AW'(in_data_i.cell_address);
            rd_ok_d = 13'(in_data_i.cell_address) < 13'(CELLS);
            state_d = S_READ;
          end else if (!consumed) begin
            case (in_data_i.char_byte)
              CH_BS:  if (col_q != '0) col_n = (CW+1)'(col_q) - (CW+1)'(1);
              CH_TAB: col_n = col_tab;
              CH_CR:  col_n = '0;
              CH_LF: begin
                col_n = '0;
                row_n = (RW+1)'(row_q) + (RW+1)'(1);
              end
              CH_FF: begin
                col_n = '0;
                row_n = '0;
              end
              default: begin
                if (in_data_i.char_byte >= CH_SPACE && in_data_i.char_byte <= CH_DEL) begin
                  we    = 1'b1;
                  waddr = cur_idx;
                  wdata = {1'b0, sgr_stat.bg, sgr_stat.fg, in_data_i.char_byte};
                  col_n = (CW+1)'(col_q) + (CW+1)'(1);
                end
              end
            endcase
            if (32'(col_n) >= COLUMNS) begin
              col_n = '0;
              row_n = row_n + (RW+1)'(1);
            end
            fill_word_d = blank;
            ptr_d       = '0;
            pend_d      = 1'b0;
            if (in_data_i.char_byte == CH_FF) begin
              state_d = S_FILL;
            end else if (32'(row_n) >= ROWS) begin
              row_n   = (RW+1)'(ROWS - 1);
              state_d = S_SCROLL;
            end
            row_d = row_n[RW-1:0];
            col_d = col_n[CW-1:0];
          end
        end
      end
      S_READ: begin
        cell_d  = rd_ok_q ? rdata : 16'd0;
        state_d = S_DONE;
      end
      S_FILL: begin
        we    = 1'b1;
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          state_d = S_DONE;
        end
      end
      S_SCROLL: begin
        // read one row below, write the previous read back one row up
        re          = 1'b1;
        raddr       = ptr_q + AW'(COLUMNS);
        we          = pend_q;
        waddr       = pend_addr_q;
        wdata       = rdata;
        pend_d      = 1'b1;
        pend_addr_d = ptr_q;
        ptr_d       = ptr_q + AW'(1);
        if (ptr_q == LAST_MOVE) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        we      = 1'b1;
        waddr   = pend_addr_q;
        wdata   = rdata;
        pend_d  = 1'b0;
        ptr_d   = LAST_ROW0;
        state_d = S_FILL;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.cell_value      = cell_q;
          out_d.cursor_location = cur_loc[10:0];
          out_d.cursor_row      = 5'(row_q);
          out_d.cursor_col      = 7'(col_q);
          out_d.escape_active   = sgr_stat.in_seq;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    fill_word_q <= fill_word_d;
    rd_ok_q     <= rd_ok_d;
    cell_q      <= cell_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/text_console_ansi_engine_test.sv -----
// Self-checking testbench for the text console engine: byte stream, SGR parser and cell reads.
`timescale 1ns / 100ps

module text_console_ansi_engine_test;
  import tcae_pkg::*;

  localparam int NCOL  = 80;
  localparam int NROW  = 25;
  localparam int NCELL = NCOL * NROW;
  localparam int NPARM = 4;
  localparam logic [2:0] ADDR_FG = 3'd0;
  localparam logic [2:0] ADDR_BG = 3'd4;
  localparam logic [7:0] CH_X    = 8'h78;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_ansi_engine dut (.*);

  always #1 clk_i = ~clk_i;

  // Console model state
  logic [15:0] screen [NCELL];
  logic [3:0]  dflt_fg, cur_fg;
  logic [2:0]  dflt_bg, cur_bg;
  logic        bold, in_esc;
  int          num_acc, num_cnt;
  int          esc_nums [NPARM];
  logic [2:0]  ansi_to_vga [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  in_item_t    pending [$];
  out_item_t   expected_beats [$];
  int          in_idle, out_idle, errors, n_items, n_reads, n_scrolls, n_seqs;
  logic        hold_off = 1'b0;

  function automatic logic [15:0] blank_cell();
    return {1'b0, cur_bg, cur_fg, CH_SPACE};
  endfunction

  task automatic console_reset();
    dflt_fg = FG_RST; dflt_bg = BG_RST;
    cur_fg = FG_RST;  cur_bg = BG_RST;
    bold = 1'b0; in_esc = 1'b0; num_acc = 0; num_cnt = 0;
    for (int i = 0; i < NPARM; i++) esc_nums[i] = 0;
    for (int i = 0; i < NCELL; i++) screen[i] = blank_cell();
  endtask

  task automatic sgr_apply(input int code);
    if (code == SGR_RESET) begin
      cur_fg = dflt_fg; cur_bg = dflt_bg; bold = 1'b0;
    end else if (code == SGR_BOLD) begin
      if (!bold) cur_fg = cur_fg + 4'd8;
      bold = 1'b1;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      cur_fg = {bold, ansi_to_vga[code - SGR_FG_LO]};
    end else if (code == SGR_FG_DEF) begin
      cur_fg = dflt_fg;
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      cur_bg = ansi_to_vga[code - SGR_BG_LO];
    end else if (code == SGR_BG_DEF) begin
      cur_bg = dflt_bg;
    end
  endtask

  task automatic stash_number();
    if (num_cnt < NPARM) begin
      esc_nums[num_cnt] = num_acc;
      num_cnt++;
    end
    num_acc = 0;
  endtask

  // Interpret one byte, cursor kept in row/col
  task automatic console_put(input logic [7:0] c, inout int row, inout int col);
    int v;
    if (in_esc) begin
      if (c == CH_LBRK) begin
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        v = num_acc * 10 + (c - CH_ZERO);
        num_acc = (v > 255) ? 255 : v;
      end else if (c == CH_SEMI) begin
        stash_number();
      end else begin
        if (c == CH_SGR_M) begin
          stash_number();
          for (int i = 0; i < num_cnt; i++) sgr_apply(esc_nums[i]);
        end
        in_esc = 1'b0; num_acc = 0; num_cnt = 0;
      end
      return;
    end
    if (c == CH_ESC) begin
      in_esc = 1'b1;
      return;
    end
    if (c == CH_BS) begin
      if (col > 0) col--;
    end else if (c == CH_TAB) begin
      col = (col + 8) & ~7;
    end else if (c == CH_CR) begin
      col = 0;
    end else if (c == CH_LF) begin
      col = 0; row++;
    end else if (c == CH_FF) begin
      for (int i = 0; i < NCELL; i++) screen[i] = blank_cell();
      row = 0; col = 0;
    end else if (c >= CH_SPACE && c <= CH_DEL) begin
      if (row * NCOL + col < NCELL) screen[row * NCOL + col] = {1'b0, cur_bg, cur_fg, c};
      col++;
    end
    if (col >= NCOL) begin
      col = 0; row++;
    end
    if (row >= NROW) begin
      for (int i = 0; i < NCELL - NCOL; i++) screen[i] = screen[i + NCOL];
      for (int i = NCELL - NCOL; i < NCELL; i++) screen[i] = blank_cell();
      row = NROW - 1;
      n_scrolls++;
    end
  endtask

  int crow = 0, ccol = 0;

  // Work out the result beat of one accepted item
  task automatic console_step(input in_item_t it);
    out_item_t r;
    int row, col;
    row = crow; col = ccol;
    r = '0;
    if (it.cmd == CMD_PUT) begin
      console_put(it.char_byte, row, col);
    end else begin
      n_reads++;
      if (it.cell_address < NCELL) r.cell_value = screen[it.cell_address];
    end
    crow = row; ccol = col;
    r.cursor_location = 11'(row * NCOL + col);
    r.cursor_row = 5'(row);
    r.cursor_col = 7'(col);
    r.escape_active = in_esc;
    expected_beats.push_back(r);
    n_items++;
  endtask

  // Driver
  always @(posedge clk_i) begin : drv
    logic taken;
    taken = in_valid_i && !in_stall_o;
    if (taken) begin
      console_step(pending.pop_front());
    end
    if (!in_valid_i || taken) begin
      if (pending.size() > 0 && !hold_off && $urandom_range(99) >= in_idle) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, got %p", $time, out_data_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: mismatch, expected %p, got %p", $time, want, out_data_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < out_idle);
  end

  task automatic put_byte(input logic [7:0] b);
    in_item_t it;
    it.cmd = CMD_PUT;
    it.char_byte = b;
    it.cell_address = 11'($urandom_range(2047));
    pending.push_back(it);
  endtask

  task automatic read_cell(input int a);
    in_item_t it;
    it.cmd = CMD_READ;
    it.char_byte = 8'($urandom_range(255));
    it.cell_address = 11'(a);
    pending.push_back(it);
  endtask

  task automatic put_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid_i || expected_beats.size() > 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_FG) dflt_fg = d[3:0];
    else dflt_bg = d[2:0];
  endtask

  // Random traffic: SGR sequences, printable text, controls and reads
  task automatic random_traffic(input int count);
    int start, pick, k;
    int codes [12] = '{0, 1, 30, 35, 36, 37, 39, 40, 44, 47, 49, 255};
    start = pending.size() + n_items;
    while (pending.size() + n_items - start < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        n_seqs++;
        put_byte(CH_ESC);
        if ($urandom_range(9) != 0) put_byte(CH_LBRK);
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++) begin
          if (i > 0) put_byte(CH_SEMI);
          case ($urandom_range(3))
            0: put_number($urandom_range(999));
            1: ;
            default: put_number(codes[$urandom_range(11)]);
          endcase
        end
        if ($urandom_range(7) == 0) put_byte(8'($urandom_range(255)));
        else put_byte(CH_SGR_M);
      end else if (pick < 40) begin
        read_cell($urandom_range(9) == 0 ? $urandom_range(2047) : $urandom_range(NCELL - 1));
      end else if (pick < 80) begin
        put_byte(8'($urandom_range(8'h7F, 8'h20)));
      end else if (pick < 85) begin
        put_byte(CH_LF);
      end else if (pick < 86) begin
        put_byte(CH_FF);
      end else if (pick < 94) begin
        case ($urandom_range(2))
          0: put_byte(CH_BS);
          1: put_byte(CH_TAB);
          default: put_byte(CH_CR);
        endcase
      end else begin
        put_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    errors = 0; n_items = 0; n_reads = 0; n_scrolls = 0; n_seqs = 0;
    in_idle = 12; out_idle = 80;
    console_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: byte extremes, controls, SGR corner cases, reads
    @(negedge clk_i);
    put_byte(8'h41); put_byte(CH_DEL); put_byte(8'h80); put_byte(8'hFF); put_byte(8'h00);
    put_byte(CH_TAB); put_byte(CH_CR); put_byte(CH_BS); put_byte(CH_LF);
    put_byte(CH_ESC); put_byte(CH_LBRK); put_number(1); put_byte(CH_SEMI);
    put_number(35); put_byte(CH_SEMI); put_number(44); put_byte(CH_SEMI);
    put_number(36); put_byte(CH_SEMI); put_number(31); put_byte(CH_SGR_M);
    put_byte(8'h5A);
    put_byte(CH_ESC); put_byte(CH_LBRK); put_number(999); put_byte(CH_SGR_M);
    put_byte(CH_ESC); put_byte(CH_ESC); put_byte(CH_ESC); put_byte(CH_X);
    put_byte(CH_ESC); put_number(49); put_byte(CH_SGR_M);
    read_cell(0); read_cell(NCOL + 1); read_cell(NCELL - 1); read_cell(2047);
    put_byte(CH_FF); read_cell(5);
    wait_idle();

    // Phase one: extreme defaults, sender rarely idle, receiver mostly stalled
    reg_write(ADDR_FG, 32'd0); reg_write(ADDR_BG, 32'd7);
    @(negedge clk_i);
    put_byte(CH_ESC); put_byte(CH_LBRK); put_number(0); put_byte(CH_SGR_M);
    random_traffic(260);
    wait_idle();

    // Phase two: roles swapped, with one full drain in the middle
    in_idle = 80; out_idle = 12;
    reg_write(ADDR_FG, 32'd15); reg_write(ADDR_BG, 32'd0);
    @(negedge clk_i);
    random_traffic(130);
    while (pending.size() > 0) @(negedge clk_i);
    hold_off = 1'b1;
    while (in_valid_i || expected_beats.size() > 0) @(negedge clk_i);
    hold_off = 1'b0;
    random_traffic(130);
    wait_idle();

    // Phase three: no idling, random defaults
    in_idle = 0; out_idle = 0;
    reg_write(ADDR_FG, 32'($urandom_range(15))); reg_write(ADDR_BG, 32'($urandom_range(7)));
    @(negedge clk_i);
    random_traffic(280);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d items: %0d reads, %0d escape sequences, %0d scrolls,", n_items,
             n_reads, n_seqs, n_scrolls);
    $display("over four default colour settings and three idle patterns; %0d errors.", errors);
    if (errors == 0) begin
      $display("text_console_ansi_engine_test OK");
    end else begin
      $display("text_console_ansi_engine_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d beats still expected", expected_beats.size());
    $display("text_console_ansi_engine_test NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
src/tcae_pkg.sv
src/tcae_cell_ram.sv
src/tcae_sgr.sv
src/text_console_ansi_engine.sv
bench/text_console_ansi_engine_test.sv
